### design/bsad_pkg.sv
// Shared types and constants for the block SAD accumulator.
// Has no dependencies; every other design file refers to it by scoped names.
package bsad_pkg;

   localparam int PIX_W       = 8;
   localparam int ROW_LANES   = 16;
   localparam int GROUP_LANES = 4;
   localparam int GROUPS      = ROW_LANES / GROUP_LANES;
   localparam int PART_W      = 10;   // four lanes of up to 255 each
   localparam int ROW_SUM_W   = 12;   // sixteen lanes of up to 255 each
   localparam int SAD_W       = 18;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 7;
   localparam int QUEUE_DEPTH = 4;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH_CODE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_ROWS = 1'd1;

   // Block width codes.
   localparam logic [1:0] WIDTH_4  = 2'd0;
   localparam logic [1:0] WIDTH_8  = 2'd1;
   localparam logic [1:0] WIDTH_16 = 2'd2;

   localparam logic [1:0] WIDTH_CODE_RESET = WIDTH_16;
   localparam logic [6:0] BLOCK_ROWS_RESET = 7'd16;

   typedef struct packed {
      logic [1:0] width_code;
      logic [6:0] block_rows;
   } bsad_cfg_type;

   // One classified row on its way from the front to the back.
   typedef struct packed {
      logic [GROUPS-1:0][PART_W-1:0] part;
      logic                          last;
   } bsad_row_type;

   // Number of lanes selected by a width code; the unused code means full width.
   function automatic logic [4:0] lanes_for_code(input logic [1:0] code);
      logic [4:0] n;
      unique case (code)
         WIDTH_4:  n = 5'd4;
         WIDTH_8:  n = 5'd8;
         default:  n = 5'd16;
      endcase
      return n;
   endfunction

endpackage

### design/bsad_front.sv
// Front part of the block SAD accumulator: lane differences, group sums and row counting.
// Depends on bsad_pkg for the configuration and row types.
module bsad_front #(
   parameter int LANES    = 16,
   parameter int MAX_ROWS = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  bsad_pkg::bsad_cfg_type cfg,
   input  logic [63:0]          src_low,
   input  logic [63:0]          src_high,
   input  logic [63:0]          ref_low,
   input  logic [63:0]          ref_high,
   output bsad_pkg::bsad_row_type row
);

   localparam int CW = $clog2(MAX_ROWS);
   localparam int RW = CW + 1;

   logic [CW-1:0] row_count_ff;
   logic [CW-1:0] row_count_in;
   logic [RW-1:0] taken;
   logic [RW-1:0] rows_eff;
   logic [6:0]    rows_raw;
   logic [4:0]    lanes_on;
   logic          last_row;
   logic [127:0]  src_all;
   logic [127:0]  ref_all;
   logic [bsad_pkg::PIX_W-1:0] s_pix [bsad_pkg::ROW_LANES];
   logic [bsad_pkg::PIX_W-1:0] r_pix [bsad_pkg::ROW_LANES];
   logic [bsad_pkg::PIX_W-1:0] diff  [bsad_pkg::ROW_LANES];

   assign src_all  = {src_high, src_low};
   assign ref_all  = {ref_high, ref_low};
   assign lanes_on = bsad_pkg::lanes_for_code(cfg.width_code);

   // Absolute difference per lane, forced to zero where the lane does not count.
   always_comb begin
      for (int i = 0; i < bsad_pkg::ROW_LANES; i++) begin
         s_pix[i] = src_all[bsad_pkg::PIX_W*i +: bsad_pkg::PIX_W];
         r_pix[i] = ref_all[bsad_pkg::PIX_W*i +: bsad_pkg::PIX_W];
         if (5'(i) < lanes_on && i < LANES) begin
            diff[i] = (s_pix[i] >= r_pix[i]) ? (s_pix[i] - r_pix[i]) : (r_pix[i] - s_pix[i]);
         end else begin
            diff[i] = '0;
         end
      end
   end

   always_comb begin
      for (int g = 0; g < bsad_pkg::GROUPS; g++) begin
         row.part[g] = bsad_pkg::PART_W'(diff[4*g])   + bsad_pkg::PART_W'(diff[4*g+1])
                     + bsad_pkg::PART_W'(diff[4*g+2]) + bsad_pkg::PART_W'(diff[4*g+3]);
      end
      row.last = last_row;
   end

   // Rows per block: zero means one, anything above the cap means the cap.
   always_comb begin
      rows_raw = cfg.block_rows;
      if (rows_raw == 7'd0) begin
         rows_raw = 7'd1;
      end else if (rows_raw > 7'(MAX_ROWS)) begin
         rows_raw = 7'(MAX_ROWS);
      end
      rows_eff = rows_raw[RW-1:0];
   end

   assign taken    = {1'b0, row_count_ff} + RW'(1);
   assign last_row = (taken >= rows_eff);

   always_comb begin
      row_count_in = row_count_ff;
      if (accept) begin
         row_count_in = last_row ? '0 : taken[CW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= '0;
      end else begin
         row_count_ff <= row_count_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_count_wraps: assert property (@(posedge clock) disable iff (reset)
      accept && row.last |=> row_count_ff == '0)
      else $error("row counter did not clear after the last row of a block");
`endif

endmodule

### design/bsad_queue.sv
// Short queue of classified rows between the front and the back part.
// Depends on bsad_pkg for the row type.
module bsad_queue #(
   parameter int DEPTH = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  bsad_pkg::bsad_row_type push_row,
   input  logic                   pop,
   output bsad_pkg::bsad_row_type head_row,
   output logic                   not_empty,
   output logic                   full
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW = $clog2(DEPTH + 1);

   bsad_pkg::bsad_row_type entries_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0] count_ff, count_in;

   assign head_row  = entries_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign full      = (count_ff == NW'(DEPTH));

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + NW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_row;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("push into a full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && !not_empty))
      else $error("pop from an empty queue");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= NW'(DEPTH))
      else $error("queue count beyond depth");
`endif

endmodule

### design/bsad_back.sv
// Back part of the block SAD accumulator: row sum, block accumulator and result register.
// Depends on bsad_pkg for the row type and widths.
module bsad_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            row_ready,
   input  bsad_pkg::bsad_row_type          head_row,
   output logic                            pop,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [bsad_pkg::SAD_W-1:0]      rsp_block_sad
);

   logic [bsad_pkg::SAD_W-1:0]     acc_ff, acc_in;
   logic [bsad_pkg::SAD_W-1:0]     sad_ff, sad_in;
   logic                           valid_ff, valid_in;
   logic [bsad_pkg::ROW_SUM_W-1:0] row_sum;
   logic [bsad_pkg::SAD_W-1:0]     sum;

   // A row that ends a block needs the result register free; others always pass.
   assign pop = row_ready && (!head_row.last || !valid_ff || !rsp_stall);

   assign row_sum = bsad_pkg::ROW_SUM_W'(head_row.part[0]) + bsad_pkg::ROW_SUM_W'(head_row.part[1])
                  + bsad_pkg::ROW_SUM_W'(head_row.part[2]) + bsad_pkg::ROW_SUM_W'(head_row.part[3]);
   assign sum     = acc_ff + bsad_pkg::SAD_W'(row_sum);

   always_comb begin
      acc_in   = acc_ff;
      sad_in   = sad_ff;
      valid_in = valid_ff && rsp_stall;
      if (pop) begin
         if (head_row.last) begin
            acc_in   = '0;
            sad_in   = sum;
            valid_in = 1'b1;
         end else begin
            acc_in = sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         acc_ff   <= acc_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sad_ff <= sad_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_block_sad = sad_ff;

`ifndef NO_ASSERTIONS
   a_last_shows: assert property (@(posedge clock) disable iff (reset)
      pop && head_row.last |=> valid_ff && acc_ff == '0)
      else $error("block end did not load the result register");
`endif

endmodule

### design/block_sad_accumulator.sv
// Top level of the block SAD accumulator: configuration registers and the three parts.
// Depends on bsad_pkg, bsad_front, bsad_queue and bsad_back.
//
//   channel   | handshake             | payload
//   ----------+-----------------------+------------------------------------------
//   request   | req_valid / req_stall | req_src_low/high, req_ref_low/high (64b)
//   response  | rsp_valid / rsp_stall | rsp_block_sad (18b)
//   config    | csr_write             | csr_index (1b), csr_wdata (7b)
//
// One row transaction is taken per cycle while the queue has space; the lane subtractors and
// group adders sit in front of the row queue, and the back part folds one queued row into the
// accumulator per cycle unless a block end waits; the total is registered behind the queue.
// Reset is synchronous and restores the width and row registers and clears the row
// counter, the queue and the accumulator. A stalled response holds the result register;
// rows still flow into the accumulator until a second block end waits on it, and the
// request side stalls only when the four-entry queue is full.
module block_sad_accumulator #(
   parameter int LANES    = 16,
   parameter int MAX_ROWS = 64
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [63:0]                           req_src_low,
   input  logic [63:0]                           req_src_high,
   input  logic [63:0]                           req_ref_low,
   input  logic [63:0]                           req_ref_high,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [bsad_pkg::SAD_W-1:0]            rsp_block_sad,
   input  logic                                  csr_write,
   input  logic [bsad_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [bsad_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   bsad_pkg::bsad_cfg_type cfg_ff, cfg_in;
   bsad_pkg::bsad_row_type front_row;
   bsad_pkg::bsad_row_type head_row;
   logic req_accept;
   logic queue_full;
   logic queue_not_empty;
   logic queue_pop;

   // Configuration writes land immediately; the width code keeps its two low bits.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            bsad_pkg::CSR_WIDTH_CODE: cfg_in.width_code = csr_wdata[1:0];
            bsad_pkg::CSR_BLOCK_ROWS: cfg_in.block_rows = csr_wdata;
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.width_code <= bsad_pkg::WIDTH_CODE_RESET;
         cfg_ff.block_rows <= bsad_pkg::BLOCK_ROWS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The request side waits only on queue space.
   assign req_stall  = queue_full;
   assign req_accept = req_valid && !queue_full;

   bsad_front #(
      .LANES    (LANES),
      .MAX_ROWS (MAX_ROWS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (req_accept),
      .cfg      (cfg_ff),
      .src_low  (req_src_low),
      .src_high (req_src_high),
      .ref_low  (req_ref_low),
      .ref_high (req_ref_high),
      .row      (front_row)
   );

   bsad_queue #(
      .DEPTH (bsad_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_accept),
      .push_row  (front_row),
      .pop       (queue_pop),
      .head_row  (head_row),
      .not_empty (queue_not_empty),
      .full      (queue_full)
   );

   bsad_back u_back (
      .clock         (clock),
      .reset         (reset),
      .row_ready     (queue_not_empty),
      .head_row      (head_row),
      .pop           (queue_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_block_sad (rsp_block_sad)
   );

`ifndef NO_ASSERTIONS
   a_stall_means_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> !queue_pop || queue_not_empty)
      else $error("request stalled with a pop from an empty queue");
`endif

endmodule

### bench/block_sad_accumulator_tb.sv
// Self-checking testbench for block_sad_accumulator: directed rows from a table, then random rows.
// Depends on bsad_pkg for the register indexes, width codes and reset values, and on the block.
// Each block sum the block returns is compared with a local model of the row accumulator.
module block_sad_accumulator_tb;

   localparam int LANES        = 16;
   localparam int MAX_ROWS     = 64;
   localparam int SAD_W        = bsad_pkg::SAD_W;
   localparam int RANDOM_ROWS  = 1600;
   // Rows can leave no result behind, so after the last expected sum the queue may still
   // hold rows. This many cycles covers the four-entry queue and the accumulator with a
   // wide margin.
   localparam int DRAIN_CYCLES = 16;
   localparam int MAX_GAP      = 12;

   // The width code that the package leaves unnamed; the block treats it as full width.
   localparam logic [1:0] WIDTH_SPARE = 2'd3;

   localparam logic [63:0] PIX_FF = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] PIX_00 = 64'h0;
   localparam logic [63:0] PAT_A  = 64'h0123_4567_89AB_CDEF;
   localparam logic [63:0] PAT_B  = 64'hFEDC_BA98_7654_3210;

   // A sum of -1 in the table means the value is left to the model.
   localparam int NO_SAD = -1;

   typedef enum {STEP_CFG, STEP_ROW} step_kind_type;

   typedef struct packed {
      logic [63:0] src_low;
      logic [63:0] src_high;
      logic [63:0] ref_low;
      logic [63:0] ref_high;
   } pix_row_type;

   typedef struct {
      step_kind_type                     kind;
      int                                count;
      logic [bsad_pkg::CSR_IDX_W-1:0]    index;
      logic [bsad_pkg::CSR_DATA_W-1:0]   wdata;
      pix_row_type                       row;
      int                                sad;
   } step_type;

   logic                               clock = 1'b0;
   logic                               reset;
   logic                               req_valid;
   logic                               req_stall;
   logic [63:0]                        req_src_low;
   logic [63:0]                        req_src_high;
   logic [63:0]                        req_ref_low;
   logic [63:0]                        req_ref_high;
   logic                               rsp_valid;
   logic                               rsp_stall = 1'b0;
   logic [SAD_W-1:0]                   rsp_block_sad;
   logic                               csr_write;
   logic [bsad_pkg::CSR_IDX_W-1:0]     csr_index;
   logic [bsad_pkg::CSR_DATA_W-1:0]    csr_wdata;

   // Model state: the two registers, the rows taken so far in this block and the partial sum.
   logic [1:0]                         cur_width;
   logic [6:0]                         cur_rows;
   logic [5:0]                         rows_taken;
   logic [SAD_W-1:0]                   run_total;

   logic [SAD_W-1:0]                   pending_sads[$];
   step_type                           plan[$];

   int   errors        = 0;
   int   sums_checked  = 0;
   int   settings_made = 0;
   int   directed_rows = 0;
   int   random_rows   = 0;
   int   hold_left     = 0;
   bit   send_steady   = 1'b0;
   bit   recv_steady   = 1'b0;

   block_sad_accumulator #(
      .LANES    (LANES),
      .MAX_ROWS (MAX_ROWS)
   ) u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_src_low   (req_src_low),
      .req_src_high  (req_src_high),
      .req_ref_low   (req_ref_low),
      .req_ref_high  (req_ref_high),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_block_sad (rsp_block_sad),
      .csr_write     (csr_write),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Fold one row into the model's running total. Returns 1 when the row closes the block,
   // with the block sum in sad; the total and the row counter then start over.
   function automatic bit predict_block_sad(input pix_row_type row,
                                            output logic [SAD_W-1:0] sad);
      logic [127:0] src_pix;
      logic [127:0] ref_pix;
      int           lanes;
      int           rows;
      int           row_sad;
      int           s;
      int           r;
      int           taken;
      src_pix = {row.src_high, row.src_low};
      ref_pix = {row.ref_high, row.ref_low};
      case (cur_width)
         bsad_pkg::WIDTH_4: lanes = 4;
         bsad_pkg::WIDTH_8: lanes = 8;
         default:           lanes = 16;
      endcase
      if (lanes > LANES) lanes = LANES;
      // A row count of zero behaves as one; anything past the cap is clipped to it.
      rows = int'(cur_rows);
      if (rows == 0) rows = 1;
      if (rows > MAX_ROWS) rows = MAX_ROWS;
      row_sad = 0;
      for (int lane = 0; lane < lanes; lane++) begin
         s = int'(src_pix[lane*8 +: 8]);
         r = int'(ref_pix[lane*8 +: 8]);
         row_sad += (s >= r) ? (s - r) : (r - s);
      end
      run_total = run_total + SAD_W'(row_sad);
      sad = run_total;
      // A register change in mid-block counts at once: the block closes as soon as the
      // rows taken reach or pass the current row count.
      taken = int'(rows_taken) + 1;
      if (taken >= rows) begin
         run_total  = '0;
         rows_taken = '0;
         return 1'b1;
      end
      rows_taken = 6'(taken);
      return 1'b0;
   endfunction

   function automatic step_type cfg_step(input logic [bsad_pkg::CSR_IDX_W-1:0] index,
                                         input logic [bsad_pkg::CSR_DATA_W-1:0] value);
      step_type st;
      st.kind  = STEP_CFG;
      st.count = 0;
      st.index = index;
      st.wdata = value;
      st.row   = '0;
      st.sad   = NO_SAD;
      return st;
   endfunction

   function automatic step_type row_step(input int count, input logic [63:0] sl,
                                         input logic [63:0] sh, input logic [63:0] rl,
                                         input logic [63:0] rh, input int sad);
      step_type st;
      st.kind  = STEP_ROW;
      st.count = count;
      st.index = '0;
      st.wdata = '0;
      st.row   = '{src_low: sl, src_high: sh, ref_low: rl, ref_high: rh};
      st.sad   = sad;
      return st;
   endfunction

   // Random row contents: mostly uniform bytes, some rows with every byte at 00 or FF,
   // and some with source equal to reference. A full-swing row gives the largest sum.
   function automatic pix_row_type random_row(input bit full_swing);
      pix_row_type row;
      int          mode;
      mode = $urandom_range(0, 7);
      row.src_low  = {$urandom, $urandom};
      row.src_high = {$urandom, $urandom};
      row.ref_low  = {$urandom, $urandom};
      row.ref_high = {$urandom, $urandom};
      if (full_swing) begin
         row = '{src_low: PIX_FF, src_high: PIX_FF, ref_low: PIX_00, ref_high: PIX_00};
      end else if (mode == 0) begin
         for (int b = 0; b < 8; b++) begin
            row.src_low[b*8 +: 8]  = {8{row.src_low[b*8]}};
            row.src_high[b*8 +: 8] = {8{row.src_high[b*8]}};
            row.ref_low[b*8 +: 8]  = {8{row.ref_low[b*8]}};
            row.ref_high[b*8 +: 8] = {8{row.ref_high[b*8]}};
         end
      end else if (mode == 1) begin
         row.ref_low  = row.src_low;
         row.ref_high = row.src_high;
      end
      return row;
   endfunction

   function automatic int draw_gap();
      return send_steady ? 0 : $urandom_range(0, MAX_GAP);
   endfunction

   task automatic report_mismatch(input string what);
      errors++;
      $display("mismatch at %0t: %s", $realtime, what);
   endtask

   // Entered and left at a falling edge. A nonzero gap drops valid first; with no gap the
   // next row follows the last one back to back.
   task automatic send_row(input pix_row_type row, input int gap, input int typed_sad);
      logic [SAD_W-1:0] sad;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_src_low  <= row.src_low;
      req_src_high <= row.src_high;
      req_ref_low  <= row.ref_low;
      req_ref_high <= row.ref_high;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (typed_sad >= 0) begin
         void'(predict_block_sad(row, sad));
         pending_sads.push_back(SAD_W'(typed_sad));
      end else if (predict_block_sad(row, sad)) begin
         pending_sads.push_back(sad);
      end
      @(negedge clock);
   endtask

   // The block counts as idle once every expected sum has come back and the rows that
   // close no block have had time to drain.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_sads.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // The write enable drops for a cycle between writes so that it is never lowered and
   // raised within one time step.
   task automatic write_csr(input logic [bsad_pkg::CSR_IDX_W-1:0] index,
                            input logic [bsad_pkg::CSR_DATA_W-1:0] value);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_write <= 1'b0;
      if (index == bsad_pkg::CSR_WIDTH_CODE) cur_width = value[1:0];
      else cur_rows = value;
      settings_made++;
      @(negedge clock);
   endtask

   // The receiver stalls a random number of cycles after each accepted transaction, or
   // not at all during a steady phase.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin : check_sums
      logic [SAD_W-1:0] want;
      if (!reset && rsp_valid && !rsp_stall) begin
         hold_left = recv_steady ? 0 : $urandom_range(0, MAX_GAP);
         if (pending_sads.size() == 0) begin
            report_mismatch($sformatf("block sum %0d with nothing pending", rsp_block_sad));
         end else begin
            want = pending_sads.pop_front();
            sums_checked++;
            if (rsp_block_sad !== want)
               report_mismatch($sformatf("block sum %0d, expected %0d", rsp_block_sad, want));
         end
      end
   end

   initial begin
      #4_000_000;
      $display("tb: failure");
      $finish;
   end

   initial begin
      int               phase;
      int               rows_in_phase;
      int               sel;
      logic [6:0]       rows_val;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_src_low  = '0;
      req_src_high = '0;
      req_ref_low  = '0;
      req_ref_high = '0;
      csr_write    = 1'b0;
      csr_index    = '0;
      csr_wdata    = '0;
      cur_width    = bsad_pkg::WIDTH_CODE_RESET;
      cur_rows     = bsad_pkg::BLOCK_ROWS_RESET;
      rows_taken   = '0;
      run_total    = '0;

      // Directed rows. The first block runs on the reset settings: sixteen rows at full
      // width, every lane 255 apart, half with source above and half below reference.
      plan.push_back(row_step(8, PIX_FF, PIX_FF, PIX_00, PIX_00, NO_SAD));
      plan.push_back(row_step(7, PIX_00, PIX_00, PIX_FF, PIX_FF, NO_SAD));
      plan.push_back(row_step(1, PIX_00, PIX_00, PIX_FF, PIX_FF, 65280));
      // A row count of zero closes a block on every row.
      plan.push_back(cfg_step(bsad_pkg::CSR_BLOCK_ROWS, 7'd0));
      plan.push_back(row_step(1, PIX_FF, PIX_FF, PIX_00, PIX_00, 4080));
      plan.push_back(row_step(1, PAT_A, PAT_B, PAT_A, PAT_B, 0));
      // Narrow widths: the lanes past the width are ignored whatever they hold.
      plan.push_back(cfg_step(bsad_pkg::CSR_WIDTH_CODE, 7'(bsad_pkg::WIDTH_4)));
      plan.push_back(row_step(1, PIX_FF, PIX_FF, PIX_00, PIX_00, 1020));
      plan.push_back(row_step(1, 64'hFFFF_FFFF_1010_1010, PIX_FF, PIX_00, PIX_00, 64));
      plan.push_back(cfg_step(bsad_pkg::CSR_WIDTH_CODE, 7'(bsad_pkg::WIDTH_8)));
      plan.push_back(row_step(1, PIX_00, PIX_00, PIX_FF, PIX_FF, 2040));
      plan.push_back(cfg_step(bsad_pkg::CSR_WIDTH_CODE, 7'(WIDTH_SPARE)));
      plan.push_back(row_step(1, PIX_FF, PIX_FF, PIX_00, PIX_00, 4080));
      // Two rows into a four-row block, then shrink the block and the width: the very
      // next row closes it.
      plan.push_back(cfg_step(bsad_pkg::CSR_BLOCK_ROWS, 7'd4));
      plan.push_back(cfg_step(bsad_pkg::CSR_WIDTH_CODE, 7'(bsad_pkg::WIDTH_16)));
      plan.push_back(row_step(2, PAT_A, PAT_B, PAT_B, PAT_A, NO_SAD));
      plan.push_back(cfg_step(bsad_pkg::CSR_BLOCK_ROWS, 7'd2));
      plan.push_back(cfg_step(bsad_pkg::CSR_WIDTH_CODE, 7'(bsad_pkg::WIDTH_4)));
      plan.push_back(row_step(1, PAT_B, PAT_A, PAT_A, PAT_B, NO_SAD));

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (plan[i]) begin
         if (plan[i].kind == STEP_CFG) begin
            wait_idle();
            write_csr(plan[i].index, plan[i].wdata);
         end else begin
            for (int k = 0; k < plan[i].count; k++)
               send_row(plan[i].row, draw_gap(), (k == plan[i].count - 1) ? plan[i].sad : NO_SAD);
            directed_rows += plan[i].count;
         end
      end

      // Random phases. The first fills a 64-row block with full-swing rows for the largest
      // possible sum; the second sets the spare width code and an over-range row count.
      // Later phases mostly use short blocks so that sums come often, and phase lengths
      // are not tied to the block size, so blocks often span a register change.
      phase = 0;
      while (random_rows < RANDOM_ROWS) begin
         wait_idle();
         send_steady = ($urandom_range(0, 3) == 0);
         recv_steady = ($urandom_range(0, 3) == 0);
         if (phase == 0) begin
            write_csr(bsad_pkg::CSR_WIDTH_CODE, 7'(bsad_pkg::WIDTH_16));
            write_csr(bsad_pkg::CSR_BLOCK_ROWS, 7'(MAX_ROWS));
            rows_in_phase = MAX_ROWS;
         end else if (phase == 1) begin
            write_csr(bsad_pkg::CSR_WIDTH_CODE, 7'(WIDTH_SPARE));
            write_csr(bsad_pkg::CSR_BLOCK_ROWS, 7'h7F);
            rows_in_phase = 150;
         end else begin
            if ($urandom_range(0, 3) != 0)
               write_csr(bsad_pkg::CSR_WIDTH_CODE, 7'($urandom_range(0, 3)));
            if ($urandom_range(0, 3) != 0) begin
               sel = $urandom_range(0, 9);
               if (sel <= 5) rows_val = 7'($urandom_range(1, 8));
               else if (sel <= 7) rows_val = 7'($urandom_range(9, MAX_ROWS));
               else if (sel == 8) rows_val = 7'd0;
               else rows_val = 7'($urandom_range(MAX_ROWS + 1, 127));
               write_csr(bsad_pkg::CSR_BLOCK_ROWS, rows_val);
            end
            rows_in_phase = $urandom_range(20, 120);
         end
         for (int k = 0; k < rows_in_phase; k++) begin
            send_row(random_row(phase == 0), draw_gap(), NO_SAD);
            random_rows++;
         end
         phase++;
      end

      wait_idle();
      $display("covered %0d directed and %0d random row transactions in %0d phases",
               directed_rows, random_rows, phase);
      $display("%0d register writes, %0d block sums compared, %0d mismatches",
               settings_made, sums_checked, errors);
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
